>>> rtl/i2c_bit_level_master_top_defines.svh
// ----------------------------------------------------------------------------
// i2c bit level master assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_TOP_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define I2CBM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define I2CBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// types and constants of the i2c bit level master
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cbm_pkg;

    // opcodes carried by an input transaction
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_WAIT  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // command codes inside the sequencer
    localparam logic [2:0] CMD_IDLE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_WAIT  = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } t_item;

    // classified tick handed from front to back
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } t_work;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_error;
    } t_result;

endpackage

>>> rtl/i2cbm_queue.sv
// ----------------------------------------------------------------------------
// i2cbm_queue
// two-entry flip-flop queue, push and pop allowed in the same cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cbm_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_head;
    logic [W-1:0] r_tail;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_head;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (do_push && do_pop) begin
            if (r_cnt == 2'd1) begin
                r_head <= i_data;
            end else begin
                r_head <= r_tail;
                r_tail <= i_data;
            end
        end else if (do_pop) begin
            r_head <= r_tail;
        end else if (do_push) begin
            if (r_cnt == 2'd0) begin
                r_head <= i_data;
            end else begin
                r_tail <= i_data;
            end
        end
    end

endmodule

>>> rtl/i2cbm_front.sv
// ----------------------------------------------------------------------------
// i2cbm_front
// accepts ticks, decodes the opcode into a command code, queues the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cbm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  i2cbm_pkg::t_item  i_item,
    output logic              o_full,
    input  logic              i_work_pop,
    output i2cbm_pkg::t_work  o_work,
    output logic              o_work_empty
);

    i2cbm_pkg::t_work cls;

    always_comb begin
        cls.write_data = i_item.write_data;
        cls.send_ack   = i_item.send_ack;
        cls.sda_in     = i_item.sda_in;
        cls.cmd        = i2cbm_pkg::CMD_IDLE;
        if (i_item.cmd_valid) begin
            case (i_item.opcode)
                i2cbm_pkg::OP_START: cls.cmd = i2cbm_pkg::CMD_START;
                i2cbm_pkg::OP_STOP:  cls.cmd = i2cbm_pkg::CMD_STOP;
                i2cbm_pkg::OP_WRITE: cls.cmd = i2cbm_pkg::CMD_WRITE;
                i2cbm_pkg::OP_WAIT:  cls.cmd = i2cbm_pkg::CMD_WAIT;
                i2cbm_pkg::OP_READ:  cls.cmd = i2cbm_pkg::CMD_READ;
                default:             cls.cmd = i2cbm_pkg::CMD_IDLE;
            endcase
        end
    end

    i2cbm_queue #(
        .W ($bits(i2cbm_pkg::t_work))
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_work_pop),
        .o_data  (o_work),
        .o_empty (o_work_empty)
    );

endmodule

>>> rtl/i2cbm_back.sv
// ----------------------------------------------------------------------------
// i2cbm_back
// phase sequencer, one tick per cycle while the result queue has room, results into a two-entry queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cbm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  i2cbm_pkg::t_work   i_work,
    input  logic               i_work_empty,
    output logic               o_work_pop,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    output i2cbm_pkg::t_result o_result,
    output logic               o_empty,
    input  logic               i_pop
);

    localparam logic [2:0] PH_0 = 3'd0;
    localparam logic [2:0] PH_1 = 3'd1;
    localparam logic [2:0] PH_2 = 3'd2;
    localparam logic [2:0] PH_3 = 3'd3;
    localparam logic [2:0] PH_4 = 3'd4;

    logic [7:0] r_limit;
    logic [2:0] r_cmd,   n_cmd;
    logic [2:0] r_phase, n_phase;
    logic [3:0] r_bits,  n_bits;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_poll,  n_poll;
    logic       r_ackc,  n_ackc;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;
    logic       r_en,    n_en;
    logic       r_err,   n_err;
    logic [7:0] r_last,  n_last;

    logic               busy;
    logic               done;
    logic               bitv;
    logic               ackl;
    logic [8:0]         poll_nx;
    logic               res_full;
    logic               take;
    i2cbm_pkg::t_result res;

    assign take       = !i_work_empty && !res_full;
    assign o_work_pop = take;

    always_comb begin
        n_cmd   = r_cmd;
        n_phase = r_phase;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_ackc  = r_ackc;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_en    = r_en;
        n_err   = r_err;
        n_last  = r_last;
        busy    = 1'b0;
        done    = 1'b0;

        // command load, only while idle
        if (r_cmd == i2cbm_pkg::CMD_IDLE && i_work.cmd != i2cbm_pkg::CMD_IDLE) begin
            n_cmd   = i_work.cmd;
            n_phase = PH_0;
            n_bits  = 4'd0;
            if (i_work.cmd == i2cbm_pkg::CMD_WRITE) begin
                n_shift = i_work.write_data;
            end
            if (i_work.cmd == i2cbm_pkg::CMD_READ) begin
                n_shift = 8'd0;
                n_ackc  = i_work.send_ack;
            end
            if (i_work.cmd == i2cbm_pkg::CMD_WAIT) begin
                n_err  = 1'b0;
                n_poll = 8'd0;
            end
        end

        bitv    = n_shift[7];
        ackl    = ~n_ackc;
        poll_nx = {1'b0, n_poll} + 9'd1;

        if (n_cmd != i2cbm_pkg::CMD_IDLE) begin
            busy = 1'b1;
            case (n_cmd)
                i2cbm_pkg::CMD_START: begin
                    if (n_phase == PH_0) begin
                        {n_scl, n_sda, n_en} = 3'b111;
                        n_phase = PH_1;
                    end else if (n_phase == PH_1) begin
                        {n_scl, n_sda, n_en} = 3'b101;
                        n_phase = PH_2;
                    end else begin
                        {n_scl, n_sda, n_en} = 3'b001;
                        done = 1'b1;
                    end
                end
                i2cbm_pkg::CMD_STOP: begin
                    if (n_phase == PH_0) begin
                        {n_scl, n_sda, n_en} = 3'b001;
                        n_phase = PH_1;
                    end else if (n_phase == PH_1) begin
                        {n_scl, n_sda, n_en} = 3'b101;
                        n_phase = PH_2;
                    end else begin
                        {n_scl, n_sda, n_en} = 3'b111;
                        done = 1'b1;
                    end
                end
                i2cbm_pkg::CMD_WRITE: begin
                    if (n_phase == PH_0) begin
                        {n_scl, n_sda, n_en} = {1'b0, bitv, 1'b1};
                        n_phase = PH_1;
                    end else if (n_phase == PH_1) begin
                        {n_scl, n_sda, n_en} = {1'b1, bitv, 1'b1};
                        n_bits = n_bits + 4'd1;
                        if (n_bits >= 4'd8) begin
                            n_phase = PH_2;
                        end else begin
                            n_shift = {n_shift[6:0], 1'b0};
                            n_phase = PH_0;
                        end
                    end else begin
                        {n_scl, n_sda, n_en} = {1'b0, bitv, 1'b1};
                        done = 1'b1;
                    end
                end
                i2cbm_pkg::CMD_WAIT: begin
                    if (n_phase == PH_0) begin
                        {n_scl, n_sda, n_en} = 3'b010;
                        n_phase = PH_1;
                    end else if (n_phase == PH_1) begin
                        {n_scl, n_sda, n_en} = 3'b110;
                        if (!i_work.sda_in) begin
                            n_phase = PH_2;
                        end else if (poll_nx > {1'b0, r_limit}) begin
                            // timeout: fall into the stop sequence
                            n_err   = 1'b1;
                            n_cmd   = i2cbm_pkg::CMD_STOP;
                            n_phase = PH_0;
                        end else begin
                            n_poll = poll_nx[7:0];
                        end
                    end else begin
                        {n_scl, n_sda, n_en} = 3'b010;
                        done = 1'b1;
                    end
                end
                i2cbm_pkg::CMD_READ: begin
                    if (n_phase == PH_0) begin
                        {n_scl, n_sda, n_en} = 3'b010;
                        n_phase = PH_1;
                    end else if (n_phase == PH_1) begin
                        {n_scl, n_sda, n_en} = 3'b110;
                        n_shift = {n_shift[6:0], i_work.sda_in};
                        n_bits  = n_bits + 4'd1;
                        n_phase = (n_bits >= 4'd8) ? PH_2 : PH_0;
                    end else if (n_phase == PH_2) begin
                        {n_scl, n_sda, n_en} = {1'b0, ackl, 1'b1};
                        n_phase = PH_3;
                    end else if (n_phase == PH_3) begin
                        {n_scl, n_sda, n_en} = {1'b1, ackl, 1'b1};
                        n_phase = PH_4;
                    end else if (n_phase == PH_4) begin
                        {n_scl, n_sda, n_en} = {1'b0, ackl, 1'b1};
                        n_last = n_shift;
                        done   = 1'b1;
                    end else begin
                        done = 1'b1;
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase
            if (done) begin
                n_cmd   = i2cbm_pkg::CMD_IDLE;
                n_phase = PH_0;
            end
        end

        res.scl_level        = n_scl;
        res.sda_level        = n_sda;
        res.sda_drive_enable = n_en;
        res.busy_res         = busy;
        res.done_res         = done;
        res.read_byte        = n_last;
        res.ack_error        = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= i2cbm_pkg::ACK_TIMEOUT_RESET;
            r_cmd   <= i2cbm_pkg::CMD_IDLE;
            r_phase <= PH_0;
            r_bits  <= 4'd0;
            r_shift <= 8'd0;
            r_poll  <= 8'd0;
            r_ackc  <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_en    <= 1'b1;
            r_err   <= 1'b0;
            r_last  <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (take) begin
                r_cmd   <= n_cmd;
                r_phase <= n_phase;
                r_bits  <= n_bits;
                r_shift <= n_shift;
                r_poll  <= n_poll;
                r_ackc  <= n_ackc;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_en    <= n_en;
                r_err   <= n_err;
                r_last  <= n_last;
            end
        end
    end

    i2cbm_queue #(
        .W ($bits(i2cbm_pkg::t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule

>>> rtl/i2c_bit_level_master_top.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master_top
// i2c master phase sequencer: one bus phase per tick transaction
// ----------------------------------------------------------------------------
// usage
//   input channel: i_item carries one tick (sda sample plus optional command),
//   taken at a clock edge with push high and full low
//   result channel: o_result holds the oldest pin/status word while empty is
//   low, taken at a clock edge with pop high
//   config channel: i_cfg_valid / o_cfg_ready write the ack timeout limit;
//   ready is always high, write only while the block is idle
// path: an accepted tick is registered in the front queue, and its result in the result queue
// throughput: one tick per cycle while the result queue has room;
//   a two-entry queue on each side lets push and pop run back to back
// reset (i_rst_n low at a clock edge): queues empty, sequencer idle, pins
//   scl high / sda high driven, timeout limit 250
// receiver stall: the result queue fills, the sequencer stops taking work,
//   then the input queue fills and full rises; nothing is lost
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_bit_level_master_top_defines.svh"

module i2c_bit_level_master_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // tick transactions in
    input  logic               push,
    input  i2cbm_pkg::t_item   i_item,
    output logic               full,
    // result transactions out
    output logic               empty,
    input  logic               pop,
    output i2cbm_pkg::t_result o_result,
    // timeout limit write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    i2cbm_pkg::t_work w_work;
    logic             w_work_empty;
    logic             w_work_pop;
    logic             w_take;

    // config is always accepted
    assign o_cfg_ready = 1'b1;
    // tick moving from front queue into the sequencer
    assign w_take = w_work_pop && !w_work_empty;

    // front: decode opcode, buffer ticks
    i2cbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_item),
        .o_full       (full),
        .i_work_pop   (w_work_pop),
        .o_work       (w_work),
        .o_work_empty (w_work_empty)
    );

    // back: sequencer plus result queue
    i2cbm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (w_work),
        .i_work_empty (w_work_empty),
        .o_work_pop   (w_work_pop),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_result     (o_result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    // accepted tick always lands in the front queue
    `I2CBM_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, push && !full, !w_work_empty, "tick lost")
    // every tick the sequencer runs leaves a result behind
    `I2CBM_ASSERT_NEXT(a_take_result, i_clk, i_rst_n, w_take, !empty, "result lost")
    // a completing phase is always a busy phase
    `I2CBM_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, !empty && o_result.done_res, o_result.busy_res, "done without busy")
    // released sda reads back high
    `I2CBM_ASSERT_NOW(a_release_high, i_clk, i_rst_n, !empty && !o_result.sda_drive_enable, o_result.sda_level, "released sda not high")

endmodule
